[rtl/core/sspfc_pkg.sv]
// ----------------------------------------------------------------------------
// Sound slot pause/fade controller package
// Shared constants, codes, slot entry layout and control bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package sspfc_pkg;

   // Slot table size and the address width that follows from it
   localparam int SLOTS   = 16;
   localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Volume a slot holds right after reset, before anything is written
   localparam logic [6:0] RESET_VOLUME = 7'd127;
   localparam logic       RESET_MIDI_INSTANT = 1'b1;

   // Request action codes
   localparam logic [2:0] ACT_TICK       = 3'd0;
   localparam logic [2:0] ACT_PLAY       = 3'd1;
   localparam logic [2:0] ACT_STOP       = 3'd2;
   localparam logic [2:0] ACT_KILL       = 3'd3;
   localparam logic [2:0] ACT_PAUSE      = 3'd4;
   localparam logic [2:0] ACT_RESUME     = 3'd5;
   localparam logic [2:0] ACT_SET_LEVEL  = 3'd6;
   localparam logic [2:0] ACT_START_FADE = 3'd7;

   // Slot status codes
   localparam logic [1:0] ST_STOPPED = 2'd0;
   localparam logic [1:0] ST_PAUSED  = 2'd1;
   localparam logic [1:0] ST_PLAYING = 2'd2;

   // Configuration register indexes
   localparam logic CSR_DEFAULT_VOLUME    = 1'b0;
   localparam logic CSR_MIDI_FADE_INSTANT = 1'b1;

   localparam logic [7:0] PAUSE_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        pause_count;
      logic [6:0]        volume;
      logic [6:0]        fade_target;
      logic signed [7:0] fade_step;
      logic [7:0]        fade_countdown;
      logic [7:0]        fade_reload;
      logic              is_midi;
      logic              fade_finished;
   } slot_entry_type;

   localparam slot_entry_type RESET_ENTRY = '{
      status:         ST_STOPPED,
      pause_count:    8'd0,
      volume:         RESET_VOLUME,
      fade_target:    7'd0,
      fade_step:      8'sd0,
      fade_countdown: 8'd0,
      fade_reload:    8'd0,
      is_midi:        1'b0,
      fade_finished:  1'b0
   };

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMD,
      S_EMPTY,
      S_SCAN,
      S_PROC
   } ctrl_state_type;

   typedef struct packed {
      logic               accept;
      logic               rd_en;
      logic [SLOT_AW-1:0] rd_addr;
      logic               wr_en;
      logic [SLOT_AW-1:0] wr_addr;
      logic               rsp_load;
      logic               rsp_empty;
      logic               rsp_last;
   } ctrl_type;

endpackage

`default_nettype wire

[rtl/core/sspfc_slot_ram.sv]
// ----------------------------------------------------------------------------
// Slot table memory
// One write port, one registered read port; per-entry valid bits make a
// never-written entry read as the reset slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sspfc_slot_ram (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rd_en,
   input  wire logic [sspfc_pkg::SLOT_AW-1:0]   rd_addr,
   output sspfc_pkg::slot_entry_type            rd_entry,
   input  wire logic                            wr_en,
   input  wire logic [sspfc_pkg::SLOT_AW-1:0]   wr_addr,
   input  wire sspfc_pkg::slot_entry_type       wr_entry
);

   sspfc_pkg::slot_entry_type mem [sspfc_pkg::SLOTS];
   logic [sspfc_pkg::SLOTS-1:0] valid_ff;
   sspfc_pkg::slot_entry_type   rdata_ff;
   logic                        rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_entry = rvalid_ff ? rdata_ff : sspfc_pkg::RESET_ENTRY;

endmodule

`default_nettype wire

[rtl/core/sspfc_update.sv]
// ----------------------------------------------------------------------------
// Slot update logic
// Computes the new slot entry for a command or for one fade tick visit.
// ----------------------------------------------------------------------------
`default_nettype none

module sspfc_update (
   input  wire sspfc_pkg::slot_entry_type cur,
   input  wire logic [2:0]           action,
   input  wire logic                 is_midi,
   input  wire logic [6:0]           level,
   input  wire logic signed [7:0]    fade_step,
   input  wire logic [7:0]           fade_interval,
   input  wire logic [6:0]           default_volume,
   input  wire logic                 midi_fade_instant,
   output sspfc_pkg::slot_entry_type nxt,
   output logic                      volume_update,
   output logic                      visit
);

   logic signed [9:0] sum;
   logic signed [9:0] tgt_x;
   logic              hit;
   logic [7:0]        pause_dec;

   // Fade step: add, then clamp at the target
   assign tgt_x = $signed({3'b000, cur.fade_target});
   assign sum   = $signed({3'b000, cur.volume}) + $signed({{2{cur.fade_step[7]}}, cur.fade_step});
   assign hit   = (!cur.fade_step[7] && (cur.fade_step != 8'sd0) && (sum >= tgt_x))
               || (cur.fade_step[7] && (sum <= tgt_x))
               || (cur.is_midi && midi_fade_instant);

   assign pause_dec = (cur.pause_count != 8'd0) ? (cur.pause_count - 8'd1) : 8'd0;

   always_comb begin
      nxt           = cur;
      volume_update = 1'b0;
      case (action)
         sspfc_pkg::ACT_TICK: begin
            if (cur.fade_countdown != 8'd0) begin
               nxt.fade_countdown = cur.fade_countdown - 8'd1;
            end else begin
               nxt.fade_countdown = cur.fade_reload;
               volume_update      = 1'b1;
               if (hit) begin
                  nxt.volume        = cur.fade_target;
                  nxt.fade_step     = 8'sd0;
                  nxt.fade_finished = 1'b1;
               end else begin
                  nxt.volume = sum[6:0];
               end
            end
         end
         sspfc_pkg::ACT_PLAY: begin
            nxt.is_midi = is_midi;
            nxt.status  = sspfc_pkg::ST_PLAYING;
         end
         sspfc_pkg::ACT_STOP: begin
            nxt.status = sspfc_pkg::ST_STOPPED;
         end
         sspfc_pkg::ACT_KILL: begin
            nxt        = sspfc_pkg::RESET_ENTRY;
            nxt.volume = default_volume;
         end
         sspfc_pkg::ACT_PAUSE: begin
            if (cur.pause_count != sspfc_pkg::PAUSE_MAX) begin
               nxt.pause_count = cur.pause_count + 8'd1;
            end
            if (cur.status == sspfc_pkg::ST_PLAYING) begin
               nxt.status = sspfc_pkg::ST_PAUSED;
            end
         end
         sspfc_pkg::ACT_RESUME: begin
            nxt.pause_count = pause_dec;
            if ((pause_dec == 8'd0) && (cur.status == sspfc_pkg::ST_PAUSED)) begin
               nxt.status = sspfc_pkg::ST_PLAYING;
            end
         end
         sspfc_pkg::ACT_SET_LEVEL: begin
            nxt.volume = level;
         end
         default: begin
            nxt.fade_target    = level;
            nxt.fade_step      = fade_step;
            nxt.fade_reload    = fade_interval;
            nxt.fade_countdown = 8'd0;
            nxt.fade_finished  = 1'b0;
         end
      endcase
   end

   assign visit = (nxt.status == sspfc_pkg::ST_PLAYING) && (nxt.fade_step != 8'sd0);

endmodule

`default_nettype wire

[rtl/core/sspfc_ctrl.sv]
// ----------------------------------------------------------------------------
// Sequencer
// Accepts requests, walks the slot table on a tick and steers the memory
// ports and the result register. Keeps one fade-active bit per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sspfc_ctrl (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_action,
   input  wire logic [3:0] req_slot,
   input  wire logic       rsp_free,
   input  wire logic       upd_visit,
   output sspfc_pkg::ctrl_type ctl
);

   sspfc_pkg::ctrl_state_type     state_ff, state_in;
   logic [sspfc_pkg::SLOTS-1:0]   mask_ff;
   logic [sspfc_pkg::SLOT_AW-1:0] cur_ff, cur_in;
   logic                          is_tick;
   logic                          out_of_range;
   logic                          more_ahead;
   logic                          cur_step;

   assign is_tick      = (req_action == sspfc_pkg::ACT_TICK);
   assign out_of_range = (32'(req_slot) >= sspfc_pkg::SLOTS);

   // Any fade-active slot above the current one still to be visited
   always_comb begin
      more_ahead = 1'b0;
      for (int j = 0; j < sspfc_pkg::SLOTS; j++) begin
         if (mask_ff[j] && (sspfc_pkg::SLOT_AW'(j) > cur_ff)) begin
            more_ahead = 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sspfc_pkg::S_IDLE: begin
            if (req_valid) begin
               if (is_tick) begin
                  state_in = (mask_ff == '0) ? sspfc_pkg::S_EMPTY : sspfc_pkg::S_SCAN;
               end else begin
                  state_in = out_of_range ? sspfc_pkg::S_EMPTY : sspfc_pkg::S_CMD;
               end
            end
         end
         sspfc_pkg::S_CMD, sspfc_pkg::S_EMPTY: begin
            if (rsp_free) begin
               state_in = sspfc_pkg::S_IDLE;
            end
         end
         sspfc_pkg::S_SCAN: begin
            if (mask_ff[cur_ff]) begin
               state_in = sspfc_pkg::S_PROC;
            end
         end
         sspfc_pkg::S_PROC: begin
            if (rsp_free) begin
               state_in = more_ahead ? sspfc_pkg::S_SCAN : sspfc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sspfc_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall     = 1'b1;
      ctl           = '0;
      ctl.rd_addr   = cur_ff;
      ctl.wr_addr   = cur_ff;
      cur_step      = 1'b0;
      case (state_ff)
         sspfc_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            ctl.accept  = req_valid;
            ctl.rd_en   = req_valid && !is_tick && !out_of_range;
            ctl.rd_addr = sspfc_pkg::SLOT_AW'(req_slot);
         end
         sspfc_pkg::S_CMD: begin
            ctl.wr_en    = rsp_free;
            ctl.rsp_load = rsp_free;
            ctl.rsp_last = 1'b1;
         end
         sspfc_pkg::S_EMPTY: begin
            ctl.rsp_load  = rsp_free;
            ctl.rsp_empty = 1'b1;
            ctl.rsp_last  = 1'b1;
         end
         sspfc_pkg::S_SCAN: begin
            ctl.rd_en = mask_ff[cur_ff];
            cur_step  = !mask_ff[cur_ff];
         end
         sspfc_pkg::S_PROC: begin
            ctl.wr_en    = rsp_free;
            ctl.rsp_load = rsp_free;
            ctl.rsp_last = !more_ahead;
            cur_step     = rsp_free && more_ahead;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      if (ctl.accept) begin
         cur_in = is_tick ? '0 : sspfc_pkg::SLOT_AW'(req_slot);
      end else if (cur_step) begin
         cur_in = cur_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sspfc_pkg::S_IDLE;
         mask_ff  <= '0;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         if (ctl.wr_en) begin
            mask_ff[ctl.wr_addr] <= upd_visit;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/sound_slot_pause_fade_controller_top.sv]
// ----------------------------------------------------------------------------
// Sound slot pause/fade controller
// Slot table of status, pause nesting, volume and fade ramp, driven by
// commands and fade ticks.
// ----------------------------------------------------------------------------
// A request is either a command for one slot (play, stop, kill, pause,
// resume, set level, start fade) or a tick. A command reads its slot from
// the table memory when it is accepted; in the command state that follows
// it writes the updated entry back and loads one response once the response
// register is free. A tick walks the slot table in ascending order from
// slot 0 and stops after the highest slot with a running fade (playing,
// nonzero step): the scan state looks at each slot up to that one and
// starts the memory read for a fading slot, and the process state then
// updates and reports that slot. A response register that stays full and
// stalled holds the sequencer while a response is ready. The final
// response of every request carries last. A tick with nothing to fade, or
// a command for a slot beyond the table, returns one response with
// valid_res low. One request is worked on at a time; the next is taken
// once the sequencer is back in idle, even while the final response still
// waits in the output register. Write the configuration registers only
// while idle; a never-written slot reads as stopped with full volume.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_slot_pause_fade_controller_top (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_action,
   input  wire logic [3:0]        req_slot,
   input  wire logic              req_is_midi,
   input  wire logic [6:0]        req_level,
   input  wire logic signed [7:0] req_fade_step,
   input  wire logic [7:0]        req_fade_interval,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid_res,
   output logic [3:0]             rsp_slot_index,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_pause_count,
   output logic [6:0]             rsp_volume,
   output logic                   rsp_fade_done,
   output logic                   rsp_volume_update,
   output logic                   rsp_last,
   // configuration
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_index,
   input  wire logic [6:0]        csr_wdata
);

   sspfc_pkg::ctrl_type       ctl;
   sspfc_pkg::slot_entry_type rd_entry;
   sspfc_pkg::slot_entry_type new_entry;
   logic                      upd_volume;
   logic                      upd_visit;
   logic                      rsp_free;

   // Configuration registers
   logic [6:0] default_volume_ff;
   logic       midi_fade_instant_ff;

   // Held request fields
   logic [2:0]        act_ff;
   logic              midi_ff;
   logic [6:0]        level_ff;
   logic signed [7:0] step_ff;
   logic [7:0]        intv_ff;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       res_valid_ff;
   logic [3:0] slot_index_ff;
   logic [1:0] status_ff;
   logic [7:0] pause_count_ff;
   logic [6:0] volume_ff;
   logic       fade_done_ff;
   logic       volume_update_ff;
   logic       last_ff;

   // Free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_volume_ff    <= sspfc_pkg::RESET_VOLUME;
         midi_fade_instant_ff <= sspfc_pkg::RESET_MIDI_INSTANT;
      end else if (csr_we) begin
         case (csr_index[0])
            sspfc_pkg::CSR_DEFAULT_VOLUME:    default_volume_ff    <= csr_wdata;
            sspfc_pkg::CSR_MIDI_FADE_INSTANT: midi_fade_instant_ff <= csr_wdata[0];
            default:                          default_volume_ff    <= default_volume_ff;
         endcase
      end
   end

   // Hold the request payload for the whole walk
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         act_ff   <= req_action;
         midi_ff  <= req_is_midi;
         level_ff <= req_level;
         step_ff  <= req_fade_step;
         intv_ff  <= req_fade_interval;
      end
   end

   sspfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_slot   (req_slot),
      .rsp_free   (rsp_free),
      .upd_visit  (upd_visit),
      .ctl        (ctl)
   );

   sspfc_slot_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (ctl.rd_en),
      .rd_addr  (ctl.rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (ctl.wr_en),
      .wr_addr  (ctl.wr_addr),
      .wr_entry (new_entry)
   );

   sspfc_update u_update (
      .cur               (rd_entry),
      .action            (act_ff),
      .is_midi           (midi_ff),
      .level             (level_ff),
      .fade_step         (step_ff),
      .fade_interval     (intv_ff),
      .default_volume    (default_volume_ff),
      .midi_fade_instant (midi_fade_instant_ff),
      .nxt               (new_entry),
      .volume_update     (upd_volume),
      .visit             (upd_visit)
   );

   // Advance the response register: load a new response, or drop the old
   // one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         last_ff <= ctl.rsp_last;
         if (ctl.rsp_empty) begin
            res_valid_ff     <= 1'b0;
            slot_index_ff    <= 4'd0;
            status_ff        <= 2'd0;
            pause_count_ff   <= 8'd0;
            volume_ff        <= 7'd0;
            fade_done_ff     <= 1'b0;
            volume_update_ff <= 1'b0;
         end else begin
            res_valid_ff     <= 1'b1;
            slot_index_ff    <= 4'(ctl.wr_addr);
            status_ff        <= new_entry.status;
            pause_count_ff   <= new_entry.pause_count;
            volume_ff        <= new_entry.volume;
            fade_done_ff     <= new_entry.fade_finished;
            volume_update_ff <= upd_volume;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valid_res     = res_valid_ff;
   assign rsp_slot_index    = slot_index_ff;
   assign rsp_status        = status_ff;
   assign rsp_pause_count   = pause_count_ff;
   assign rsp_volume        = volume_ff;
   assign rsp_fade_done     = fade_done_ff;
   assign rsp_volume_update = volume_update_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire
